// ===== design/pse_pkg.sv =====
// pse_pkg: shared types and constants of the postfix stack evaluator
// used by pse_front, pse_back and postfix_stack_evaluator_unit; no dependencies
package pse_pkg;

   // operand stack geometry
   localparam int STACK_DEPTH = 16;
   localparam int STACK_AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int STACK_CW    = $clog2(STACK_DEPTH + 1);

   // command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // character codes
   localparam logic [7:0] CHAR_PLUS = 8'h2B;
   localparam logic [7:0] CHAR_STAR = 8'h2A;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;

   localparam int VALUE_W = 32;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_UNDERFLOW = 2'd1,
      ST_OVERFLOW  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      OP_DIGIT = 2'd0,
      OP_ADD   = 2'd1,
      OP_MUL   = 2'd2,
      OP_OTHER = 2'd3
   } op_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      status_type                status;
   } rsp_type;

   // classified character as it travels through the queue
   typedef struct packed {
      op_type     op;
      logic [3:0] digit;
      logic       last;
   } cmd_type;

endpackage

// ===== design/pse_front.sv =====
// pse_front: accepts characters, classifies them and holds them in a short queue
// depends on pse_pkg
module pse_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pse_pkg::req_type req_word,
   output logic             cmd_valid,
   input  logic             cmd_ready,
   output pse_pkg::cmd_type cmd_word
);
   import pse_pkg::*;

   cmd_type               queue_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]   fill_ff, fill_in;
   cmd_type               cmd_new;
   logic [7:0]            digit_wide;
   logic                  push, pop;

   // classify the incoming character
   always_comb begin
      digit_wide       = req_word.char_code - CHAR_ZERO;
      cmd_new.digit    = digit_wide[3:0];
      cmd_new.last     = req_word.last_char;
      unique case (req_word.char_code) inside
         [CHAR_ZERO:CHAR_NINE]: cmd_new.op = OP_DIGIT;
         CHAR_PLUS:             cmd_new.op = OP_ADD;
         CHAR_STAR:             cmd_new.op = OP_MUL;
         default:               cmd_new.op = OP_OTHER;
      endcase
   end

   assign req_ready = (fill_ff != QUEUE_CW'(QUEUE_DEPTH));
   assign cmd_valid = (fill_ff != '0);
   assign cmd_word  = queue_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

// ===== design/pse_back.sv =====
// pse_back: executes queued commands on the operand stack and holds the result word
// depends on pse_pkg
module pse_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  pse_pkg::cmd_type cmd_word,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pse_pkg::rsp_type rsp_word
);
   import pse_pkg::*;

   // top two entries in registers, deeper entries in the memory
   logic [VALUE_W-1:0]  mem [STACK_DEPTH];
   logic [VALUE_W-1:0]  tos_ff, tos_in;
   logic [VALUE_W-1:0]  nos_ff, nos_in;
   logic [VALUE_W-1:0]  rd_data_ff;
   logic [VALUE_W-1:0]  byp_data_ff;
   logic                byp_ff, byp_in;
   logic [STACK_CW-1:0] count_ff, count_in;
   logic                in_num_ff, in_num_in;
   status_type          err_ff, err_in;
   logic                out_valid_ff, out_valid_in;
   rsp_type             out_word_ff, out_word_in;

   logic                slot_free, go;
   logic                mem_we;
   logic [STACK_CW-1:0] wr_pos, rd_pos;
   logic [VALUE_W-1:0]  third, prod, times_ten, sum;
   status_type          fin_err;

   assign third     = byp_ff ? byp_data_ff : rd_data_ff;
   assign slot_free = !out_valid_ff || rsp_ready;
   assign cmd_ready = !cmd_word.last || slot_free;
   assign go        = cmd_valid && cmd_ready;
   assign prod      = nos_ff * tos_ff;
   assign sum       = nos_ff + tos_ff;
   assign times_ten = (tos_ff << 3) + (tos_ff << 1) + {{(VALUE_W-4){1'b0}}, cmd_word.digit};
   assign wr_pos    = count_ff - STACK_CW'(2);

   always_comb begin
      tos_in       = tos_ff;
      nos_in       = nos_ff;
      count_in     = count_ff;
      in_num_in    = in_num_ff;
      err_in       = err_ff;
      mem_we       = 1'b0;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_word_in  = out_word_ff;
      fin_err      = ST_OK;

      if (go && err_ff == ST_OK) begin
         unique case (cmd_word.op) inside
            OP_DIGIT: begin
               if (!in_num_ff) begin
                  if (count_ff >= STACK_CW'(STACK_DEPTH)) begin
                     err_in = ST_OVERFLOW;
                  end else begin
                     tos_in    = {{(VALUE_W-4){1'b0}}, cmd_word.digit};
                     nos_in    = tos_ff;
                     mem_we    = (count_ff >= STACK_CW'(2));
                     count_in  = count_ff + 1'b1;
                     in_num_in = 1'b1;
                  end
               end else begin
                  tos_in = times_ten;
               end
            end
            OP_ADD, OP_MUL: begin
               in_num_in = 1'b0;
               if (count_ff < STACK_CW'(2)) begin
                  err_in = ST_UNDERFLOW;
               end else begin
                  tos_in   = (cmd_word.op == OP_ADD) ? sum : prod;
                  nos_in   = third;
                  count_in = count_ff - 1'b1;
               end
            end
            default: begin
               in_num_in = 1'b0;
            end
         endcase
      end

      // final pop and return to the empty state
      if (go && cmd_word.last) begin
         fin_err = err_in;
         if (fin_err == ST_OK && count_in == '0) begin
            fin_err = ST_UNDERFLOW;
         end
         out_valid_in       = 1'b1;
         out_word_in.status = fin_err;
         out_word_in.value  = (fin_err == ST_OK) ? $signed(tos_in) : '0;
         count_in           = '0;
         in_num_in          = 1'b0;
         err_in             = ST_OK;
      end
   end

   // the entry below the new second entry; on a push it is the word just spilled
   assign rd_pos = count_in - STACK_CW'(3);
   assign byp_in = mem_we;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_pos[STACK_AW-1:0]] <= nos_ff;
      end
      rd_data_ff  <= mem[rd_pos[STACK_AW-1:0]];
      byp_data_ff <= nos_ff;
      tos_ff      <= tos_in;
      nos_ff      <= nos_in;
      out_word_ff <= out_word_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         in_num_ff    <= 1'b0;
         err_ff       <= ST_OK;
         byp_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         in_num_ff    <= in_num_in;
         err_ff       <= err_in;
         byp_ff       <= byp_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

endmodule

// ===== design/postfix_stack_evaluator_unit.sv =====
// postfix stack evaluator: one character word per cycle, sustained unless the back stalls
// the last character leaves the queue, then the back registers the result word for rsp
// one char per cycle unless stalled; the back stack step (one add or multiply) sets it
// a waiting result word stalls the back only on the next last character
// reset is synchronous; it empties the queue and the stack, stack memory is not cleared
module postfix_stack_evaluator_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pse_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pse_pkg::rsp_type rsp_word
);
   import pse_pkg::*;

   // classified character between front and back
   logic    cmd_valid;
   logic    cmd_ready;
   cmd_type cmd_word;

   // front: classify digit, plus, star or other and queue the command
   pse_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd_word  (cmd_word)
   );

   // back: stack step per command, final pop into the output register
   pse_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd_word  (cmd_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

endmodule
